// ===== rtl/core/rv64im_execute_alu_top_defines.svh =====
// Assertion macros used by the execute unit top level.
`ifndef RV64IM_EXECUTE_ALU_TOP_DEFINES_SVH
`define RV64IM_EXECUTE_ALU_TOP_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define RVEX_ASSERT_IMPLIES(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("execute unit check failed");

// Condition must never be seen.
`define RVEX_ASSERT_NEVER(label, cond) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("execute unit forbidden condition");

`endif

// ===== rtl/core/rvex_pkg.sv =====
// Shared types and constants of the RV64IM execute unit.
package rvex_pkg;

  localparam int unsigned PORT_W     = 64;
  localparam int unsigned CMD_W      = 5;
  localparam int unsigned IMM_W      = 32;
  localparam int unsigned INSN_BYTES = 4;

  typedef enum logic [CMD_W-1:0] {
    CMD_LUI    = 5'd0,
    CMD_AUIPC  = 5'd1,
    CMD_JAL    = 5'd2,
    CMD_STORE  = 5'd3,
    CMD_ADD    = 5'd4,
    CMD_SUB    = 5'd5,
    CMD_SLL    = 5'd6,
    CMD_SLT    = 5'd7,
    CMD_SLTU   = 5'd8,
    CMD_OR     = 5'd9,
    CMD_AND    = 5'd10,
    CMD_MUL    = 5'd11,
    CMD_MULH   = 5'd12,
    CMD_MULHSU = 5'd13,
    CMD_MULHU  = 5'd14,
    CMD_DIV    = 5'd15,
    CMD_DIVU   = 5'd16,
    CMD_REM    = 5'd17,
    CMD_REMU   = 5'd18,
    CMD_ADDW   = 5'd19,
    CMD_SUBW   = 5'd20,
    CMD_SLLW   = 5'd21,
    CMD_SRLW   = 5'd22,
    CMD_SRAW   = 5'd23
  } cmd_t;

  typedef struct packed {
    logic want_hi;
    logic signed_a;
    logic signed_b;
  } mul_ctl_t;

endpackage

// ===== rtl/core/rvex_mul.sv =====
// Four-stage pipelined XLEN x XLEN multiplier built from 32x32 partial products.
module rvex_mul #(
  parameter int unsigned XLEN = 64
) (
  input  logic                  clk,
  input  logic [XLEN-1:0]       a,
  input  logic [XLEN-1:0]       b,
  input  rvex_pkg::mul_ctl_t    ctl,
  output logic [XLEN-1:0]       product
);

  logic [63:0]  a64, b64;
  logic [63:0]  p00, p01, p10, p11;
  logic [XLEN-1:0] corr_a, corr_b, corr_c;
  rvex_pkg::mul_ctl_t ctl_a, ctl_b, ctl_c;
  logic [63:0]  p00_b, p11_b;
  logic [64:0]  mid;
  logic [127:0] full;
  logic [XLEN-1:0] hi;

  assign a64 = 64'(a);
  assign b64 = 64'(b);

  always_ff @(posedge clk) begin
    p00    <= a64[31:0] * b64[31:0];
    p01    <= a64[31:0] * b64[63:32];
    p10    <= a64[63:32] * b64[31:0];
    p11    <= a64[63:32] * b64[63:32];
    // signed high-half correction: subtract the other operand per negative input
    corr_a <= ((ctl.signed_a && a[XLEN-1]) ? b : '0)
            + ((ctl.signed_b && b[XLEN-1]) ? a : '0);
    ctl_a  <= ctl;
  end

  always_ff @(posedge clk) begin
    mid    <= 65'(p01) + 65'(p10);
    p00_b  <= p00;
    p11_b  <= p11;
    corr_b <= corr_a;
    ctl_b  <= ctl_a;
  end

  always_ff @(posedge clk) begin
    full   <= {p11_b, p00_b} + (128'(mid) << 32);
    corr_c <= corr_b;
    ctl_c  <= ctl_b;
  end

  assign hi = full[2*XLEN-1:XLEN] - corr_c;

  always_ff @(posedge clk) begin
    product <= ctl_c.want_hi ? hi : full[XLEN-1:0];
  end

endmodule

// ===== rtl/core/rvex_div.sv =====
// Fully pipelined restoring divider: one stage per quotient bit.
module rvex_div #(
  parameter int unsigned XLEN = 64
) (
  input  logic            clk,
  input  logic [XLEN-1:0] dividend,
  input  logic [XLEN-1:0] divisor,
  output logic [XLEN-1:0] quotient,
  output logic [XLEN-1:0] remainder
);

  logic [XLEN-1:0] rem_s [0:XLEN];
  logic [XLEN-1:0] quo_s [0:XLEN];
  logic [XLEN-1:0] dvs_s [0:XLEN];

  assign rem_s[0] = '0;
  assign quo_s[0] = dividend;
  assign dvs_s[0] = divisor;

  for (genvar k = 0; k < XLEN; k++) begin : g_stage
    logic [XLEN:0] shifted;
    logic [XLEN:0] diff;

    assign shifted = {rem_s[k], quo_s[k][XLEN-1]};
    assign diff    = shifted - {1'b0, dvs_s[k]};

    always_ff @(posedge clk) begin
      // keep the shifted remainder when the trial subtract goes negative
      rem_s[k+1] <= diff[XLEN] ? shifted[XLEN-1:0] : diff[XLEN-1:0];
      quo_s[k+1] <= {quo_s[k][XLEN-2:0], ~diff[XLEN]};
      dvs_s[k+1] <= dvs_s[k];
    end
  end

  assign quotient  = quo_s[XLEN];
  assign remainder = rem_s[XLEN];

endmodule

// ===== rtl/core/rv64im_execute_alu_top.sv =====
// Top level of the pipelined RV64IM integer execute unit.
// Takes one instruction per cycle while busy is low, with no other stall; every
// result, whatever the operation, appears on write_value and target_address with
// done high after the input, stage-2, divider-aligned and output registers, and
// is taken at the edge that ends the cycle in which done is high. The restoring
// divider spends one pipeline stage per quotient bit; all other operations are
// delayed to match so results leave in order. The receiver cannot hold results off.
// busy is high only while rst is high.
`include "rv64im_execute_alu_top_defines.svh"

module rv64im_execute_alu_top #(
  parameter int unsigned XLEN = 64
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  output logic                               busy,
  input  logic [rvex_pkg::CMD_W-1:0]         command,
  input  logic [rvex_pkg::PORT_W-1:0]        first_operand,
  input  logic [rvex_pkg::PORT_W-1:0]        second_operand,
  input  logic signed [rvex_pkg::IMM_W-1:0]  immediate,
  input  logic [rvex_pkg::PORT_W-1:0]        instr_pc,
  output logic                               done,
  output logic [rvex_pkg::PORT_W-1:0]        write_value,
  output logic [rvex_pkg::PORT_W-1:0]        target_address
);

  localparam int unsigned SHW       = $clog2(XLEN);
  localparam int unsigned MUL_STAGE = 4;

  typedef struct packed {
    rvex_pkg::cmd_t  cmd;
    logic [XLEN-1:0] val;
    logic [XLEN-1:0] tgt;
    logic            neg_q;
    logic            neg_r;
  } side_t;

  // stage 1: registered inputs
  logic            v1;
  logic [rvex_pkg::CMD_W-1:0] cmd1;
  logic [XLEN-1:0] a1, b1, imm1, pc1;

  // stage 2: simple results and divider operands
  logic            v2;
  side_t           side2, side2_next;
  logic [XLEN-1:0] ua2, ub2, ua_next, ub_next;

  // divider-aligned stages
  logic            vs   [1:XLEN];
  side_t           side [1:XLEN];
  side_t           side_mul;

  rvex_pkg::mul_ctl_t mctl;
  logic [XLEN-1:0] mul_product;
  logic [XLEN-1:0] quotient, remainder;
  logic [XLEN-1:0] fin_val, q_fix, r_fix;

  logic [31:0] w_sum, w_dif, w_sll, w_srl, w_sra;
  logic        na, nb, sdiv;
  rvex_pkg::cmd_t c1;

  assign busy = rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= start && !busy;
    end
    cmd1 <= command;
    a1   <= first_operand[XLEN-1:0];
    b1   <= second_operand[XLEN-1:0];
    imm1 <= XLEN'(immediate);
    pc1  <= instr_pc[XLEN-1:0];
  end

  assign c1    = rvex_pkg::cmd_t'(cmd1);
  assign w_sum = a1[31:0] + b1[31:0];
  assign w_dif = a1[31:0] - b1[31:0];
  assign w_sll = a1[31:0] << b1[4:0];
  assign w_srl = a1[31:0] >> b1[4:0];
  assign w_sra = $signed(a1[31:0]) >>> b1[4:0];
  assign sdiv  = (c1 == rvex_pkg::CMD_DIV) || (c1 == rvex_pkg::CMD_REM);
  assign na    = sdiv && a1[XLEN-1];
  assign nb    = sdiv && b1[XLEN-1];

  always_comb begin
    side2_next       = '0;
    side2_next.cmd   = c1;
    ua_next          = na ? (XLEN'(0) - a1) : a1;
    ub_next          = nb ? (XLEN'(0) - b1) : b1;
    // a zero divisor already yields all ones; hold off the sign fix-up
    side2_next.neg_q = (na ^ nb) && (b1 != '0);
    side2_next.neg_r = na;
    unique case (c1)
      rvex_pkg::CMD_LUI:   side2_next.val = imm1;
      rvex_pkg::CMD_AUIPC: begin
        side2_next.val = pc1 + imm1;
        side2_next.tgt = pc1 + imm1;
      end
      rvex_pkg::CMD_JAL: begin
        side2_next.val = pc1 + XLEN'(rvex_pkg::INSN_BYTES);
        side2_next.tgt = pc1 + imm1;
      end
      rvex_pkg::CMD_STORE: begin
        side2_next.val = b1;
        side2_next.tgt = a1 + imm1;
      end
      rvex_pkg::CMD_ADD:   side2_next.val = a1 + b1;
      rvex_pkg::CMD_SUB:   side2_next.val = a1 - b1;
      rvex_pkg::CMD_SLL:   side2_next.val = a1 << b1[SHW-1:0];
      rvex_pkg::CMD_SLT:   side2_next.val = XLEN'($signed(a1) < $signed(b1));
      rvex_pkg::CMD_SLTU:  side2_next.val = XLEN'(a1 < b1);
      rvex_pkg::CMD_OR:    side2_next.val = a1 | b1;
      rvex_pkg::CMD_AND:   side2_next.val = a1 & b1;
      rvex_pkg::CMD_ADDW:  side2_next.val = XLEN'($signed(w_sum));
      rvex_pkg::CMD_SUBW:  side2_next.val = XLEN'($signed(w_dif));
      rvex_pkg::CMD_SLLW:  side2_next.val = XLEN'($signed(w_sll));
      rvex_pkg::CMD_SRLW:  side2_next.val = XLEN'($signed(w_srl));
      rvex_pkg::CMD_SRAW:  side2_next.val = XLEN'($signed(w_sra));
      default:             side2_next.val = '0;
    endcase
  end

  always_comb begin
    mctl.want_hi  = (c1 == rvex_pkg::CMD_MULH) || (c1 == rvex_pkg::CMD_MULHSU)
                 || (c1 == rvex_pkg::CMD_MULHU);
    mctl.signed_a = (c1 == rvex_pkg::CMD_MULH) || (c1 == rvex_pkg::CMD_MULHSU);
    mctl.signed_b = (c1 == rvex_pkg::CMD_MULH);
  end

  rvex_mul #(.XLEN(XLEN)) u_mul (
    .clk     (clk),
    .a       (a1),
    .b       (b1),
    .ctl     (mctl),
    .product (mul_product)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else begin
      v2 <= v1;
    end
    side2 <= side2_next;
    ua2   <= ua_next;
    ub2   <= ub_next;
  end

  rvex_div #(.XLEN(XLEN)) u_div (
    .clk       (clk),
    .dividend  (ua2),
    .divisor   (ub2),
    .quotient  (quotient),
    .remainder (remainder)
  );

  always_comb begin
    side_mul = side[MUL_STAGE-1];
    // merge the multiplier result once it leaves its last stage
    if (side[MUL_STAGE-1].cmd == rvex_pkg::CMD_MUL
        || side[MUL_STAGE-1].cmd == rvex_pkg::CMD_MULH
        || side[MUL_STAGE-1].cmd == rvex_pkg::CMD_MULHSU
        || side[MUL_STAGE-1].cmd == rvex_pkg::CMD_MULHU) begin
      side_mul.val = mul_product;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 1; k <= XLEN; k++) begin
        vs[k] <= 1'b0;
      end
    end else begin
      vs[1] <= v2;
      for (int k = 2; k <= XLEN; k++) begin
        vs[k] <= vs[k-1];
      end
    end
    side[1] <= side2;
    for (int k = 2; k <= XLEN; k++) begin
      side[k] <= (k == MUL_STAGE) ? side_mul : side[k-1];
    end
  end

  assign q_fix = side[XLEN].neg_q ? (XLEN'(0) - quotient) : quotient;
  assign r_fix = side[XLEN].neg_r ? (XLEN'(0) - remainder) : remainder;

  always_comb begin
    priority if (side[XLEN].cmd == rvex_pkg::CMD_DIV
                 || side[XLEN].cmd == rvex_pkg::CMD_DIVU) begin
      fin_val = q_fix;
    end else if (side[XLEN].cmd == rvex_pkg::CMD_REM
                 || side[XLEN].cmd == rvex_pkg::CMD_REMU) begin
      fin_val = r_fix;
    end else begin
      fin_val = side[XLEN].val;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= vs[XLEN];
    end
    write_value    <= rvex_pkg::PORT_W'(fin_val);
    target_address <= rvex_pkg::PORT_W'(side[XLEN].tgt);
  end

  `RVEX_ASSERT_IMPLIES(a_chain_depth, vs[XLEN], $past(v2, XLEN))
  `RVEX_ASSERT_IMPLIES(a_plain_no_target, vs[XLEN] && side[XLEN].cmd == rvex_pkg::CMD_ADD, side[XLEN].tgt == '0)
  `RVEX_ASSERT_NEVER(a_busy_accept, done && $past(rst))

endmodule

// ===== dv/tb_rv64im_execute_alu_top.sv =====
// Self-checking testbench for the pipelined RV64IM execute unit.
module tb_rv64im_execute_alu_top;
  timeunit 1ns;
  timeprecision 1ps;
  import rvex_pkg::*;

  typedef struct {
    logic [63:0] wval;
    logic [63:0] taddr;
  } exec_result_t;

  int unsigned mismatches = 0;

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("mismatch %s: got %h want %h", what, got, want);
    mismatches++;
  endtask

  // Reference of the RV64IM execute semantics.
  function automatic exec_result_t execute_insn(logic [4:0] op, logic [63:0] a,
                                                logic [63:0] b, logic [31:0] imm32,
                                                logic [63:0] pc);
    exec_result_t r;
    logic [63:0] imm;
    logic [127:0] prod;
    logic [63:0] ua, ub, q;
    logic [31:0] w;
    r.wval = '0;
    r.taddr = '0;
    imm = {{32{imm32[31]}}, imm32};
    case (op)
      CMD_LUI: r.wval = imm;
      CMD_AUIPC: begin
        r.wval = pc + imm;
        r.taddr = pc + imm;
      end
      CMD_JAL: begin
        r.wval = pc + INSN_BYTES;
        r.taddr = pc + imm;
      end
      CMD_STORE: begin
        r.wval = b;
        r.taddr = a + imm;
      end
      CMD_ADD: r.wval = a + b;
      CMD_SUB: r.wval = a - b;
      CMD_SLL: r.wval = a << b[5:0];
      CMD_SLT: r.wval = ($signed(a) < $signed(b)) ? 64'd1 : 64'd0;
      CMD_SLTU: r.wval = (a < b) ? 64'd1 : 64'd0;
      CMD_OR: r.wval = a | b;
      CMD_AND: r.wval = a & b;
      CMD_MUL: r.wval = a * b;
      CMD_MULH: begin
        prod = $signed({{64{a[63]}}, a}) * $signed({{64{b[63]}}, b});
        r.wval = prod[127:64];
      end
      CMD_MULHSU: begin
        prod = {{64{a[63]}}, a} * {64'd0, b};
        r.wval = prod[127:64];
      end
      CMD_MULHU: begin
        prod = {64'd0, a} * {64'd0, b};
        r.wval = prod[127:64];
      end
      CMD_DIV, CMD_REM: begin
        ua = a[63] ? -a : a;
        ub = b[63] ? -b : b;
        if (b == 0) r.wval = (op == CMD_DIV) ? '1 : a;
        else if (op == CMD_REM) begin
          q = ua % ub;
          r.wval = a[63] ? -q : q;
        end else begin
          q = ua / ub;
          r.wval = (a[63] != b[63]) ? -q : q;
        end
      end
      CMD_DIVU: r.wval = (b == 0) ? '1 : a / b;
      CMD_REMU: r.wval = (b == 0) ? a : a % b;
      CMD_ADDW, CMD_SUBW, CMD_SLLW, CMD_SRLW, CMD_SRAW: begin
        case (op)
          CMD_ADDW: w = a[31:0] + b[31:0];
          CMD_SUBW: w = a[31:0] - b[31:0];
          CMD_SLLW: w = a[31:0] << b[4:0];
          CMD_SRLW: w = a[31:0] >> b[4:0];
          default: w = $signed(a[31:0]) >>> b[4:0];
        endcase
        r.wval = {{32{w[31]}}, w};
      end
      default: ;
    endcase
    return r;
  endfunction

  class exec_scoreboard;
    exec_result_t pending[$];
    int unsigned checked = 0;

    function void note_insn(logic [4:0] op, logic [63:0] a, logic [63:0] b,
                            logic [31:0] imm, logic [63:0] pc);
      pending.push_back(execute_insn(op, a, b, imm, pc));
    endfunction

    task check_result(logic [63:0] wv, logic [63:0] ta);
      exec_result_t e;
      if (pending.size() == 0) begin
        report_mismatch("unexpected result", wv, '0);
      end else begin
        e = pending.pop_front();
        if (wv !== e.wval) report_mismatch("write_value", wv, e.wval);
        if (ta !== e.taddr) report_mismatch("target_address", ta, e.taddr);
        checked++;
      end
    endtask
  endclass

  logic clk = 0;
  logic rst = 1;
  logic start = 0;
  logic busy, done;
  logic [CMD_W-1:0] command = '0;
  logic [PORT_W-1:0] first_operand = '0, second_operand = '0, instr_pc = '0;
  logic signed [IMM_W-1:0] immediate = '0;
  logic [PORT_W-1:0] write_value, target_address;

  exec_scoreboard sb = new();

  rv64im_execute_alu_top dut (.*);

  always #4 clk = ~clk;

  always @(posedge clk) begin
    if (!rst && start && !busy)
      sb.note_insn(command, first_operand, second_operand, immediate, instr_pc);
    if (!rst && done) sb.check_result(write_value, target_address);
  end

  function automatic logic [63:0] pick_value();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      2: return 64'h8000_0000_0000_0000;
      3: return 64'h7fff_ffff_ffff_ffff;
      4: return {32'd0, $urandom()};
      5: return {{32{1'b1}}, $urandom()};
      6: return 64'($urandom_range(0, 70));
      default: return {$urandom(), $urandom()};
    endcase
  endfunction

  // Drop start over the gap, then hold it for one item until the block takes it.
  task automatic issue_insn(logic [4:0] op, logic [63:0] a, logic [63:0] b,
                            logic [31:0] imm, logic [63:0] pc, int unsigned gap);
    if (gap != 0) begin
      start <= 0;
      repeat (gap) @(posedge clk);
    end
    start <= 1;
    command <= op;
    first_operand <= a;
    second_operand <= b;
    immediate <= imm;
    instr_pc <= pc;
    do @(posedge clk); while (busy);
  endtask

  localparam logic [63:0] MIN_NEG = 64'h8000_0000_0000_0000;
  int unsigned burst;

  initial begin
    repeat (4) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    // Extremes, every op, divide by zero, signed overflow and unused codes.
    for (int op = 0; op < 24; op++)
      issue_insn(5'(op), '1, MIN_NEG, 32'h8000_0000, '1, 0);
    issue_insn(CMD_DIV, MIN_NEG, '1, 32'h7fff_ffff, '0, 0);
    issue_insn(CMD_REM, MIN_NEG, '1, '0, '0, 0);
    issue_insn(CMD_DIV, 64'd5, '0, '0, '0, 0);
    issue_insn(CMD_REMU, 64'd5, '0, '0, '0, 0);
    issue_insn(5'd24, '1, '1, '1, '1, 0);
    issue_insn(5'd31, '0, '0, '0, '0, 0);
    for (int n = 0; n < 800; n++) begin
      burst = $urandom_range(0, 3);
      issue_insn($urandom_range(0, 15) == 0 ? 5'($urandom_range(24, 31))
                                            : 5'($urandom_range(0, 23)),
                 pick_value(), pick_value(), $urandom(), pick_value(),
                 burst == 0 ? 0 : $urandom_range(0, 11));
    end
    start <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
    $display("checked %0d results across all 24 operations, unused codes,", sb.checked);
    $display("operand extremes and divide corner cases");
    if (mismatches == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

  initial begin
    #2ms;
    $display("status: fail");
    $finish;
  end
endmodule
